@@ sv/aec_pkg.sv @@
`default_nettype none

package aec_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int MAX_DELAY_DEFAULT = 65536;
  localparam int SINE_TABLE_BITS_DEFAULT = 10;

  localparam int MUL_W = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RND_W = PROD_W - 16;
  localparam int SUM_W = RND_W + 2;
  localparam int SINE_W = 18;
  localparam int DEPTH_W = 17;
  localparam int MOD_W = 18;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [DEPTH_W-1:0] ONE_Q16 = DEPTH_W'(65536);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [1:0] LAST_SLOT = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STAGE_ORDER,
    REG_GAIN_FACTOR,
    REG_ECHO_DELAY,
    REG_ECHO_DECAY,
    REG_PHASE_STEP,
    REG_DEPTH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_GAIN,
    SEL_ECHO,
    SEL_TREM
  } stage_sel_t;

  typedef enum logic [3:0] {
    PC_IDLE,
    PC_DISP,
    PC_G0,
    PC_G1,
    PC_E0,
    PC_E1,
    PC_E2,
    PC_T0,
    PC_T1,
    PC_T2,
    PC_T3,
    PC_NEXT,
    PC_FIN
  } pc_t;

  typedef enum logic [1:0] {
    MUL_GAIN,
    MUL_ECHO,
    MUL_DEPTH,
    MUL_MOD
  } mul_sel_t;

  typedef enum logic [1:0] {
    X_HOLD,
    X_ROUND,
    X_ECHO
  } x_op_t;

  typedef enum logic [2:0] {
    J_GOTO,
    J_WAIT_IN,
    J_DISPATCH,
    J_SLOT,
    J_WAIT_OUT
  } jump_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    x_op_t    x_op;
    logic     mod_load;
    logic     echo_access;
    jump_t    jump;
    pc_t      target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   accept;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic echo_ok;
    logic trem_ok;
  } status_t;

  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    w = '{mul_sel: MUL_GAIN, x_op: X_HOLD, mod_load: 1'b0, echo_access: 1'b0,
          jump: J_GOTO, target: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.jump = J_WAIT_IN;
        w.target = PC_DISP;
      end
      PC_DISP: w.jump = J_DISPATCH;
      PC_G0: begin
        w.mul_sel = MUL_GAIN;
        w.target = PC_G1;
      end
      PC_G1: begin
        w.x_op = X_ROUND;
        w.target = PC_NEXT;
      end
      PC_E0: begin
        w.echo_access = 1'b1;
        w.target = PC_E1;
      end
      PC_E1: begin
        w.mul_sel = MUL_ECHO;
        w.target = PC_E2;
      end
      PC_E2: begin
        w.x_op = X_ECHO;
        w.target = PC_NEXT;
      end
      PC_T0: begin
        w.mul_sel = MUL_DEPTH;
        w.target = PC_T1;
      end
      PC_T1: begin
        w.mod_load = 1'b1;
        w.target = PC_T2;
      end
      PC_T2: begin
        w.mul_sel = MUL_MOD;
        w.target = PC_T3;
      end
      PC_T3: begin
        w.x_op = X_ROUND;
        w.target = PC_NEXT;
      end
      PC_NEXT: begin
        w.jump = J_SLOT;
        w.target = PC_FIN;
      end
      PC_FIN: begin
        w.jump = J_WAIT_OUT;
        w.target = PC_IDLE;
      end
      default: begin
        w.jump = J_GOTO;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  // Long division, evaluated only while the sine table constants are built.
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine entry in Q16 from a Q30 Taylor series up to x^17.
  function automatic logic [DEPTH_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint unsigned n;
    x = (longint'(k) * HALF_PI_Q30) >> (bits - 2);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 8; n++) begin
      term = long_div((term * x2) >> 30, (2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = longint'((unsigned'(sum) + 8192) >> 14);
    if (sum > 65536) begin
      sum = 65536;
    end
    return DEPTH_W'(sum);
  endfunction

endpackage

`default_nettype wire

@@ sv/aec_sequencer.sv @@
`default_nettype none

module aec_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [5:0]       stage_order,
  input  wire aec_pkg::status_t status,
  output aec_pkg::ctrl_t        ctrl,
  output logic                  in_ready
);

  aec_pkg::pc_t       pc;
  aec_pkg::pc_t       pc_next;
  logic [1:0]         slot;
  logic [1:0]         slot_next;
  logic               echo_used;
  logic               echo_used_next;
  aec_pkg::ucode_t    uc;
  aec_pkg::stage_sel_t sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= aec_pkg::PC_IDLE;
      slot <= '0;
      echo_used <= 1'b0;
    end else begin
      pc <= pc_next;
      slot <= slot_next;
      echo_used <= echo_used_next;
    end
  end

  always_comb begin
    uc = aec_pkg::ucode(pc);
    sel = aec_pkg::stage_sel_t'(stage_order[2*slot +: 2]);
    pc_next = pc;
    slot_next = slot;
    echo_used_next = echo_used;
    ctrl.accept = 1'b0;
    ctrl.out_load = 1'b0;
    case (uc.jump)
      aec_pkg::J_GOTO: pc_next = uc.target;
      aec_pkg::J_WAIT_IN: begin
        if (status.in_valid) begin
          pc_next = uc.target;
          ctrl.accept = 1'b1;
          slot_next = '0;
          echo_used_next = 1'b0;
        end
      end
      aec_pkg::J_DISPATCH: begin
        case (sel)
          aec_pkg::SEL_GAIN: pc_next = aec_pkg::PC_G0;
          aec_pkg::SEL_ECHO: begin
            echo_used_next = 1'b1;
            pc_next = (status.echo_ok && !echo_used) ? aec_pkg::PC_E0 : aec_pkg::PC_NEXT;
          end
          aec_pkg::SEL_TREM: begin
            pc_next = status.trem_ok ? aec_pkg::PC_T0 : aec_pkg::PC_NEXT;
          end
          default: pc_next = aec_pkg::PC_NEXT;
        endcase
      end
      aec_pkg::J_SLOT: begin
        if (slot == aec_pkg::LAST_SLOT) begin
          pc_next = uc.target;
        end else begin
          slot_next = slot + 2'd1;
          pc_next = aec_pkg::PC_DISP;
        end
      end
      aec_pkg::J_WAIT_OUT: begin
        if (status.out_free) begin
          pc_next = uc.target;
          ctrl.out_load = 1'b1;
        end
      end
      default: pc_next = aec_pkg::PC_IDLE;
    endcase
    ctrl.uc = uc;
    in_ready = (uc.jump == aec_pkg::J_WAIT_IN);
  end

endmodule

`default_nettype wire

@@ sv/aec_echo_line.sv @@
`default_nettype none

module aec_echo_line #(
  parameter int MAX_DELAY = aec_pkg::MAX_DELAY_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire aec_pkg::ctrl_t                      ctrl,
  input  wire logic                                first,
  input  wire logic [15:0]                         delay,
  input  wire logic signed [aec_pkg::SAMPLE_WIDTH-1:0] wdata,
  output logic signed [aec_pkg::SAMPLE_WIDTH-1:0]  delayed
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW = $clog2(MAX_DELAY + 1);
  localparam int EW = ((CW > 16) ? CW : 16) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_DELAY);
  localparam logic [EW-1:0] DEPTH_E = EW'(MAX_DELAY);

  logic signed [aec_pkg::SAMPLE_WIDTH-1:0] mem [MAX_DELAY];
  logic signed [aec_pkg::SAMPLE_WIDTH-1:0] rdata;
  logic [AW-1:0] wr_index;
  logic [CW-1:0] fill;
  logic          hit;
  logic [EW-1:0] delay_e;
  logic [EW-1:0] diff;
  logic [EW-1:0] wrapped;
  logic [AW-1:0] raddr;

  always_comb begin
    delay_e = EW'(delay);
    diff = EW'(wr_index) - delay_e;
    wrapped = diff[EW-1] ? (diff + DEPTH_E) : diff;
    raddr = wrapped[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.uc.echo_access) begin
      rdata <= mem[raddr];
      mem[wr_index] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uc.echo_access) begin
      hit <= (EW'(fill) >= delay_e) && (delay_e <= DEPTH_E);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_index <= '0;
      fill <= '0;
    end else if (ctrl.accept && first) begin
      wr_index <= '0;
      fill <= '0;
    end else if (ctrl.uc.echo_access) begin
      wr_index <= (wr_index == LAST_ADDR) ? '0 : wr_index + AW'(1);
      if (fill < FULL) begin
        fill <= fill + CW'(1);
      end
    end
  end

  assign delayed = hit ? rdata : '0;

endmodule

`default_nettype wire

@@ sv/aec_sine_rom.sv @@
`default_nettype none

module aec_sine_rom #(
  parameter int SINE_TABLE_BITS = aec_pkg::SINE_TABLE_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire aec_pkg::ctrl_t                ctrl,
  input  wire logic                          first,
  input  wire logic [31:0]                   phase_step,
  output logic signed [aec_pkg::SINE_W-1:0]  sine
);

  localparam int B = SINE_TABLE_BITS;
  localparam int QUARTER = 1 << (B - 2);
  localparam logic [B-2:0] QUARTER_V = (B - 1)'(QUARTER);

  logic [aec_pkg::DEPTH_W-1:0] qtab [QUARTER + 1];
  logic [31:0]                 phase;
  logic [B-1:0]                idx;
  logic [B-2:0]                addr;
  logic [aec_pkg::SINE_W-1:0]  mag;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    localparam logic [aec_pkg::DEPTH_W-1:0] ENTRY = aec_pkg::quarter_sine(k, B);
    assign qtab[k] = ENTRY;
  end

  always_comb begin
    idx = phase[31 -: B];
    if (idx[B-2]) begin
      addr = QUARTER_V - (B - 1)'(idx[B-3:0]);
    end else begin
      addr = (B - 1)'(idx[B-3:0]);
    end
    mag = aec_pkg::SINE_W'(qtab[addr]);
  end

  always_ff @(posedge clk) begin
    sine <= idx[B-1] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctrl.accept && first) begin
      phase <= '0;
    end else if (ctrl.out_load) begin
      phase <= phase + phase_step;
    end
  end

endmodule

`default_nettype wire

@@ sv/aec_datapath.sv @@
`default_nettype none

module aec_datapath (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire aec_pkg::ctrl_t                          ctrl,
  input  wire logic signed [aec_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic signed [23:0]                      gain,
  input  wire logic signed [17:0]                      decay,
  input  wire logic [aec_pkg::DEPTH_W-1:0]             depth,
  input  wire logic signed [aec_pkg::SAMPLE_WIDTH-1:0] delayed,
  input  wire logic signed [aec_pkg::SINE_W-1:0]       sine,
  input  wire logic                                    out_ready,
  output logic signed [aec_pkg::SAMPLE_WIDTH-1:0]      x,
  output logic signed [aec_pkg::SAMPLE_WIDTH-1:0]      sample_out,
  output logic                                         out_valid
);

  logic signed [aec_pkg::MUL_W-1:0]  mul_a;
  logic signed [aec_pkg::MUL_W-1:0]  mul_b;
  logic signed [aec_pkg::PROD_W-1:0] prod;
  logic signed [aec_pkg::RND_W-1:0]  rnd;
  logic signed [aec_pkg::MOD_W-1:0]  mod;
  logic signed [aec_pkg::MOD_W+1:0]  mod_full;
  logic signed [aec_pkg::SUM_W-1:0]  echo_sum;

  always_comb begin
    case (ctrl.uc.mul_sel)
      aec_pkg::MUL_GAIN: begin
        mul_a = aec_pkg::MUL_W'(x);
        mul_b = aec_pkg::MUL_W'(gain);
      end
      aec_pkg::MUL_ECHO: begin
        mul_a = aec_pkg::MUL_W'(decay);
        mul_b = aec_pkg::MUL_W'(delayed);
      end
      aec_pkg::MUL_DEPTH: begin
        mul_a = aec_pkg::MUL_W'($signed({1'b0, depth}));
        mul_b = aec_pkg::MUL_W'(sine);
      end
      default: begin
        mul_a = aec_pkg::MUL_W'(x);
        mul_b = aec_pkg::MUL_W'(mod);
      end
    endcase
    rnd = aec_pkg::round_q16(prod);
    echo_sum = aec_pkg::SUM_W'(x) + aec_pkg::SUM_W'(rnd);
    mod_full = (aec_pkg::MOD_W + 2)'($signed({1'b0, aec_pkg::ONE_Q16}))
             - (aec_pkg::MOD_W + 2)'($signed({1'b0, depth}))
             + (aec_pkg::MOD_W + 2)'(rnd);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctrl.uc.mod_load) begin
      mod <= mod_full[aec_pkg::MOD_W-1:0];
    end
    if (ctrl.accept) begin
      x <= sample_in;
    end else begin
      case (ctrl.uc.x_op)
        aec_pkg::X_ROUND: x <= aec_pkg::sat(aec_pkg::SUM_W'(rnd));
        aec_pkg::X_ECHO:  x <= aec_pkg::sat(echo_sum);
        default:          x <= x;
      endcase
    end
    if (ctrl.out_load) begin
      sample_out <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/audio_effect_chain_unit.sv @@
// Channel   Handshake             Payload
// in        in_valid / in_ready   sample_in[23:0] signed, first
// out       out_valid / out_ready sample_out[23:0] signed
// cfg       cfg_valid / cfg_ready cfg_index[2:0], cfg_data[31:0]
//
// A request is accepted; each of the three slots then runs its gain, echo or tremolo step or
// is skipped when unused or bypassed; then the result is handed off, before the next request.
// The steps are set by the microcode program, which drives one shared 24x24 multiplier.
// Reset is synchronous: clears sequencer, echo indexes, phase, config (gain factor to 65536).
// A result waits in the output register; the next request is accepted while it waits.
// The hand-off step stalls only when the output register is still full and not taken.
`default_nettype none

module audio_effect_chain_unit #(
  parameter int MAX_DELAY = aec_pkg::MAX_DELAY_DEFAULT,
  parameter int SINE_TABLE_BITS = aec_pkg::SINE_TABLE_BITS_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [aec_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic                                   first,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [aec_pkg::SAMPLE_WIDTH-1:0]     sample_out,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [aec_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [aec_pkg::CFG_DATA_W-1:0]         cfg_data
);

  logic [5:0]                  stage_order;
  logic signed [23:0]          gain_factor;
  logic [15:0]                 echo_delay_samples;
  logic signed [17:0]          echo_decay;
  logic [31:0]                 tremolo_phase_step;
  logic [aec_pkg::DEPTH_W-1:0] tremolo_depth;
  logic [aec_pkg::DEPTH_W-1:0] depth_clamped;

  aec_pkg::ctrl_t   ctrl;
  aec_pkg::status_t status;

  logic signed [aec_pkg::SAMPLE_WIDTH-1:0] x;
  logic signed [aec_pkg::SAMPLE_WIDTH-1:0] delayed;
  logic signed [aec_pkg::SINE_W-1:0]       sine;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_order <= '0;
      gain_factor <= 24'sd65536;
      echo_delay_samples <= '0;
      echo_decay <= '0;
      tremolo_phase_step <= '0;
      tremolo_depth <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (aec_pkg::cfg_reg_t'(cfg_index))
        aec_pkg::REG_STAGE_ORDER: stage_order <= cfg_data[5:0];
        aec_pkg::REG_GAIN_FACTOR: gain_factor <= cfg_data[23:0];
        aec_pkg::REG_ECHO_DELAY:  echo_delay_samples <= cfg_data[15:0];
        aec_pkg::REG_ECHO_DECAY:  echo_decay <= cfg_data[17:0];
        aec_pkg::REG_PHASE_STEP:  tremolo_phase_step <= cfg_data;
        aec_pkg::REG_DEPTH:       tremolo_depth <= cfg_data[aec_pkg::DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    depth_clamped = (tremolo_depth > aec_pkg::ONE_Q16) ? aec_pkg::ONE_Q16 : tremolo_depth;
    status.in_valid = in_valid;
    status.out_free = !out_valid || out_ready;
    status.echo_ok = (echo_delay_samples != '0) && (echo_decay != '0);
    status.trem_ok = (tremolo_phase_step != '0) && (tremolo_depth != '0);
  end

  aec_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .stage_order (stage_order),
    .status      (status),
    .ctrl        (ctrl),
    .in_ready    (in_ready)
  );

  aec_echo_line #(
    .MAX_DELAY (MAX_DELAY)
  ) u_echo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .first   (first),
    .delay   (echo_delay_samples),
    .wdata   (x),
    .delayed (delayed)
  );

  aec_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .first      (first),
    .phase_step (tremolo_phase_step),
    .sine       (sine)
  );

  aec_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_in  (sample_in),
    .gain       (gain_factor),
    .decay      (echo_decay),
    .depth      (depth_clamped),
    .delayed    (delayed),
    .sine       (sine),
    .out_ready  (out_ready),
    .x          (x),
    .sample_out (sample_out),
    .out_valid  (out_valid)
  );

endmodule

`default_nettype wire

@@ sv/aec_checker.sv @@
`default_nettype none

module aec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] sample_out
);

  logic [2:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, in_take} - {2'b00, out_take};
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("request accepted while the previous one is still in work");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 3'd0))
    else $error("result shown without an outstanding request");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more requests outstanding than the block can hold");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("stalled result dropped or changed");

endmodule

bind audio_effect_chain_unit aec_checker u_aec_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

`default_nettype wire
